FILE: rtl/nqb_pkg.sv
// Shared constants, types and the attack-check request for the N-queens search.
`default_nettype none

package nqb_pkg;

    // Field widths fixed by the stream format
    localparam int ROW_W       = 3;   // row minus one of one queen
    localparam int CNT_W       = 4;   // column, row candidate and board edge counters
    localparam int SOL_W       = 7;   // running solution number
    localparam int ROWS_W      = 24;  // packed rows of all columns
    localparam int CFG_W       = 4;   // board_size register
    localparam int MAX_BOARD_DEF = 8; // default built board edge
    localparam logic [CFG_W-1:0] BOARD_RESET = 4'd8;

    // Search phase kept between requests
    typedef enum logic [1:0] {
        PH_FRESH = 2'd0,
        PH_RUN   = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    // One compare job for the attack unit
    typedef struct packed {
        logic [ROW_W-1:0] q;  // row of the earlier queen
        logic [CNT_W-1:0] r;  // candidate row
        logic [CNT_W-1:0] d;  // column distance
    } attack_req_t;

endpackage

`default_nettype wire

FILE: rtl/nqb_attack_unit.sv
// Shared attack compare: same row or either left diagonal of one earlier queen.
`default_nettype none

module nqb_attack_unit
    import nqb_pkg::*;
(
    input  attack_req_t req,
    output logic        hit
);

    logic [CNT_W:0] q_ext;
    logic [CNT_W:0] r_ext;
    logic [CNT_W:0] d_ext;

    // Widen so the diagonal sums cannot wrap
    assign q_ext = {{(CNT_W + 1 - ROW_W){1'b0}}, req.q};
    assign r_ext = {1'b0, req.r};
    assign d_ext = {1'b0, req.d};

    // Flag row clash, falling diagonal or rising diagonal
    assign hit = (q_ext == r_ext) ||
                 ((q_ext + d_ext) == r_ext) ||
                 ((r_ext + d_ext) == q_ext);

endmodule

`default_nettype wire

FILE: rtl/n_queens_backtrack_search.sv
// Top level: sequenced depth-first N-queens search, one solution or exhaustion report per request beat.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata[0] restart
//  m_        out  m_tvalid/m_tready    m_tdata queen_rows, solution_number; m_tuser found
//  cfg_      in   cfg_we               cfg_wdata board_size
//
// A request passes through an accept step, a try step for each candidate row, each backtrack
// and the closing test, a check step for each earlier column compared and for each queen
// placed, and an emit step, all through the single shared attack compare unit; a request
// on an exhausted search goes straight from the accept step to the emit step.
// Reset restores board_size 8 and clears the search, with no sweep.
// The result register holds a stalled beat; the next request may start meanwhile
// and waits in the emit step for the register before it delivers.
`default_nettype none

module n_queens_backtrack_search
    import nqb_pkg::*;
#(
    parameter int MAX_BOARD = MAX_BOARD_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    // request: bit 0 restart, bits 7..1 zero
    input  wire  [7:0]       s_tdata,
    input  wire              s_tvalid,
    output logic             s_tready,
    // result: bits 23..0 queen_rows, bits 30..24 solution_number, bit 31 zero
    output logic [31:0]      m_tdata,
    // result: bit 0 found
    output logic             m_tuser,
    output logic             m_tvalid,
    input  wire              m_tready,
    input  wire              cfg_we,
    input  wire  [CFG_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_BOARD);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_TRY   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CFG_W-1:0]    board_reg, board_next;
    logic [ROW_W-1:0]    rows_reg [MAX_BOARD];
    logic [ROW_W-1:0]    rows_next [MAX_BOARD];
    logic [CNT_W-1:0]    col_reg, col_next;
    logic [SOL_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    r_reg, r_next;
    logic [CNT_W-1:0]    c_reg, c_next;
    logic                found_reg, found_next;
    logic                m_valid_reg, m_valid_next;
    logic [ROWS_W-1:0]   m_rows_reg, m_rows_next;
    logic [SOL_W-1:0]    m_num_reg, m_num_next;
    logic                m_found_reg, m_found_next;

    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W-1:0]    k_start;
    logic [CNT_W-1:0]    rd_idx;
    logic [ROW_W-1:0]    rd_q;
    logic [ROWS_W-1:0]   packed_rows;
    attack_req_t         atk_req;
    logic                atk_hit;

    // Clamp the board edge into 1..MAX_BOARD
    always_comb begin
        if (board_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (board_reg > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = board_reg;
        end
    end

    // Column to resume from when continuing a running search
    assign k_start = (col_reg >= CNT_W'(1) && col_reg <= n_eff) ? col_reg - CNT_W'(1)
                                                               : n_eff - CNT_W'(1);

    // Single read port on the queen rows
    always_comb begin
        case (state_reg)
            ST_IDLE: rd_idx = k_start;
            ST_TRY:  rd_idx = k_reg - CNT_W'(1);
            default: rd_idx = c_reg;
        endcase
    end
    assign rd_q = rows_reg[rd_idx[IDX_W-1:0]];

    // Shared attack compare against the earlier column under test
    assign atk_req.q = rd_q;
    assign atk_req.r = r_reg;
    assign atk_req.d = k_reg - c_reg;

    nqb_attack_unit u_attack (
        .req (atk_req),
        .hit (atk_hit)
    );

    // Pack the placed rows, columns past the edge read zero
    always_comb begin
        packed_rows = '0;
        for (int i = 0; i < MAX_BOARD; i++) begin
            if (CNT_W'(i) < n_eff) begin
                packed_rows[ROW_W*i +: ROW_W] = rows_reg[i];
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Search sequencer
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        board_next   = board_reg;
        rows_next    = rows_reg;
        col_next     = col_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_rows_next  = m_rows_reg;
        m_num_next   = m_num_reg;
        m_found_next = m_found_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[0]) begin
                        for (int i = 0; i < MAX_BOARD; i++) begin
                            rows_next[i] = '0;
                        end
                        col_next   = '0;
                        count_next = '0;
                        phase_next = PH_FRESH;
                    end
                    if (s_tdata[0] || phase_reg == PH_FRESH) begin
                        k_next     = '0;
                        r_next     = '0;
                        state_next = ST_TRY;
                    end else if (phase_reg == PH_RUN) begin
                        // Step the last queen past its current row
                        k_next = k_start;
                        r_next = {{(CNT_W - ROW_W){1'b0}}, rd_q} + CNT_W'(1);
                        rows_next[k_start[IDX_W-1:0]] = '0;
                        state_next = ST_TRY;
                    end else begin
                        found_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_TRY: begin
                if (k_reg >= n_eff) begin
                    col_next   = n_eff;
                    found_next = 1'b1;
                    state_next = ST_EMIT;
                end else if (r_reg >= n_eff) begin
                    if (k_reg == '0) begin
                        col_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_EMIT;
                    end else begin
                        // Backtrack one column and resume past its row
                        k_next = k_reg - CNT_W'(1);
                        r_next = {{(CNT_W - ROW_W){1'b0}}, rd_q} + CNT_W'(1);
                        rows_next[rd_idx[IDX_W-1:0]] = '0;
                    end
                end else begin
                    c_next     = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (c_reg == k_reg) begin
                    // No earlier queen attacks: place and advance
                    rows_next[k_reg[IDX_W-1:0]] = r_reg[ROW_W-1:0];
                    k_next     = k_reg + CNT_W'(1);
                    r_next     = '0;
                    state_next = ST_TRY;
                end else if (atk_hit) begin
                    r_next     = r_reg + CNT_W'(1);
                    state_next = ST_TRY;
                end else begin
                    c_next = c_reg + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    if (found_reg) begin
                        m_rows_next = packed_rows;
                        m_num_next  = count_reg + SOL_W'(1);
                        count_next  = count_reg + SOL_W'(1);
                        phase_next  = PH_RUN;
                    end else begin
                        m_rows_next = '0;
                        m_num_next  = count_reg;
                        phase_next  = PH_DONE;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write restarts the search
        if (cfg_we) begin
            board_next = cfg_wdata;
            for (int i = 0; i < MAX_BOARD; i++) begin
                rows_next[i] = '0;
            end
            col_next   = '0;
            count_next = '0;
            phase_next = PH_FRESH;
        end
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FRESH;
            board_reg   <= BOARD_RESET;
            for (int i = 0; i < MAX_BOARD; i++) begin
                rows_reg[i] <= '0;
            end
            col_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            board_reg   <= board_next;
            rows_reg    <= rows_next;
            col_reg     <= col_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working counters and result payload
    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        found_reg   <= found_next;
        m_rows_reg  <= m_rows_next;
        m_num_reg   <= m_num_next;
        m_found_reg <= m_found_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {1'b0, m_num_reg, m_rows_reg};

endmodule

`default_nettype wire

FILE: rtl/nqb_checker.sv
// Port-level checks for the N-queens search, bound to the top level.
`default_nettype none

module nqb_checker (
    input wire              aclk,
    input wire              aresetn,
    input wire              s_tvalid,
    input wire              s_tready,
    input wire  [31:0]      m_tdata,
    input wire              m_tuser,
    input wire              m_tvalid,
    input wire              m_tready
);

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Search stays busy in the cycle after a request beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while search running");

    // Exhausted search reports an empty board
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23:0] == 24'd0)
        else $error("rows present without a solution");

    // A solution always carries a nonzero number
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[30:24] != 7'd0)
        else $error("solution with zero number");

endmodule

bind n_queens_backtrack_search nqb_checker u_nqb_checker (.*);

`default_nettype wire

FILE: test/tb_n_queens_backtrack_search.sv
// Testbench for the N-queens backtracking search: self-predicting stream driver and checker.
`timescale 1ns / 100ps

module tb_n_queens_backtrack_search;
    import nqb_pkg::*;

    localparam int MAX_BOARD   = MAX_BOARD_DEF;
    localparam int QUIET_LIMIT = 100000;  // cycles without any beat before giving up
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int RAND_ITEMS  = 1020;    // random part with idling
    localparam int TOTAL_ITEMS = 1170;    // then a calm tail up to this many

    // One expected result beat
    typedef struct packed {
        logic [ROWS_W-1:0] rows;
        logic              found;
        logic [SOL_W-1:0]  sol;
    } sol_beat_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic [7:0]       s_tdata   = 8'd0;    // bit 0 restart, bits 7..1 zero
    logic             s_tvalid  = 1'b0;
    wire              s_tready;
    wire  [31:0]      m_tdata;             // bits 23..0 queen_rows, 30..24 solution_number
    wire              m_tuser;             // bit 0 found
    wire              m_tvalid;
    logic             m_tready  = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    n_queens_backtrack_search #(
        .MAX_BOARD (MAX_BOARD)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus bookkeeping
    bit        restart_feed[$];
    sol_beat_t solution_due[$];
    int        n_pushed   = 0;
    int        n_taken    = 0;
    int        n_returned = 0;
    int        n_bad      = 0;
    int        quiet      = 0;
    bit        idle_on    = 1'b1;
    bit        calm       = 1'b0;
    int        hold_requests = 0;
    int        hold_served   = 0;
    int        hold_left     = 0;
    int        src_gap       = 0;
    int        sink_gap      = 0;
    logic      req_beat      = 1'b0;

    // Own copy of the search state
    logic [CFG_W-1:0] pm_board;
    logic [ROW_W-1:0] pm_row [8];
    logic [CNT_W-1:0] pm_col;
    phase_t           pm_phase;
    logic [SOL_W-1:0] pm_count;

    function automatic int board_edge();
        int n;
        n = int'(pm_board);
        if (n < 1) n = 1;
        if (n > MAX_BOARD) n = MAX_BOARD;
        return n;
    endfunction

    function automatic void clear_board();
        for (int c = 0; c < 8; c++) pm_row[c] = '0;
        pm_col   = '0;
        pm_phase = PH_FRESH;
        pm_count = '0;
    endfunction

    // Row r in column k is free of every queen to its left
    function automatic bit safe_square(int r, int k);
        int q;
        int d;
        for (int c = 0; c < k && c < 8; c++) begin
            q = int'(pm_row[c]);
            d = k - c;
            if (q == r || q + d == r || r + d == q) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Depth-first walk from column k, first candidate row start
    function automatic bit place_queens(int k0, int start0, int n);
        int  k;
        int  start;
        int  r;
        bit  placed;
        k = k0;
        start = start0;
        while (1'b1) begin
            if (k >= n) begin
                pm_col = CNT_W'(n);
                return 1'b1;
            end
            placed = 1'b0;
            for (r = start; r < n && !placed; r++) begin
                if (safe_square(r, k)) begin
                    pm_row[k] = ROW_W'(r);
                    placed = 1'b1;
                end
            end
            if (placed) begin
                k++;
                start = 0;
            end else begin
                if (k == 0) begin
                    pm_col = '0;
                    return 1'b0;
                end
                k--;
                start = int'(pm_row[k]) + 1;
                pm_row[k] = '0;
            end
        end
        return 1'b0;
    endfunction

    function automatic sol_beat_t next_solution(logic restart);
        sol_beat_t b;
        int        n;
        int        k;
        int        st;
        int        col;
        bit        ok;
        n  = board_edge();
        ok = 1'b0;
        if (restart) clear_board();
        if (pm_phase == PH_FRESH) begin
            ok = place_queens(0, 0, n);
        end else if (pm_phase == PH_RUN) begin
            col = int'(pm_col);
            k  = (col >= 1 && col <= n) ? col - 1 : n - 1;
            st = int'(pm_row[k]) + 1;
            pm_row[k] = '0;
            ok = place_queens(k, st, n);
        end
        b.rows = '0;
        if (ok) begin
            pm_phase = PH_RUN;
            pm_count = pm_count + SOL_W'(1);
            for (int c = 0; c < n; c++) b.rows[3*c +: 3] = pm_row[c];
        end else begin
            pm_phase = PH_DONE;
        end
        b.found = ok;
        b.sol   = pm_count;
        return b;
    endfunction

    // Note each accepted request beat for the sender
    always @(posedge aclk) begin
        req_beat <= aresetn && s_tvalid && s_tready;
    end

    // Present queued requests, with random gaps after beats
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || req_beat)) begin
            if (src_gap != 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (restart_feed.size() != 0) begin
                s_tdata  <= {7'd0, restart_feed.pop_front()};
                s_tvalid <= 1'b1;
                if (idle_on && !calm && $urandom_range(0, 3) == 0)
                    src_gap <= $urandom_range(1, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Drive result ready: long hold-offs on request, short stall bursts otherwise
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && !calm && $urandom_range(0, 5) == 0)
                sink_gap <= $urandom_range(1, 10);
        end
    end

    // Check result beats, then predict for accepted requests and config writes
    always @(posedge aclk) begin : monitor
        sol_beat_t want;
        sol_beat_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.rows  = m_tdata[ROWS_W-1:0];
                got.sol   = m_tdata[30:24];
                got.found = m_tuser;
                n_returned <= n_returned + 1;
                if (solution_due.size() == 0) begin
                    if (n_bad < 10)
                        $display("%0t: result beat with nothing expected: tdata=%h tuser=%b",
                                 $realtime, m_tdata, m_tuser);
                    n_bad = n_bad + 1;
                end else begin
                    want = solution_due.pop_front();
                    if (got !== want || m_tdata[31] !== 1'b0) begin
                        if (n_bad < 10)
                            $display("%0t: mismatch rows %h/%h found %b/%b sol %0d/%0d (exp/act)",
                                     $realtime, want.rows, got.rows, want.found, got.found,
                                     want.sol, got.sol);
                        n_bad = n_bad + 1;
                    end
                end
            end
            if (cfg_we) begin
                pm_board = cfg_wdata;
                clear_board();
            end
            if (s_tvalid && s_tready) begin
                solution_due.push_back(next_solution(s_tdata[0]));
                n_taken <= n_taken + 1;
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_req(bit restart);
        restart_feed.push_back(restart);
        n_pushed++;
    endtask

    // Hold until every request is accepted and answered, then let the block settle
    task automatic wait_drained();
        while (n_taken != n_pushed || n_returned != n_pushed) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_board(logic [CFG_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int  pick;
        int  count;
        int  big_walks;
        bit  noisy;
        logic [CFG_W-1:0] size;

        pm_board = BOARD_RESET;
        clear_board();
        big_walks = 0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset board: first two solutions, then restart to the first again
        push_req(1'b0);
        push_req(1'b0);
        push_req(1'b1);

        // Single square: one solution, exhaustion that sticks, restart
        set_board(4'd1);
        push_req(1'b0);
        push_req(1'b0);
        push_req(1'b0);
        push_req(1'b1);

        // Zero acts as one
        set_board(4'd0);
        push_req(1'b0);
        push_req(1'b0);

        // Boards with no solution at all
        set_board(4'd2);
        push_req(1'b0);
        push_req(1'b1);
        set_board(4'd3);
        push_req(1'b0);

        // Full walk of the four board through exhaustion and restart
        set_board(4'd4);
        repeat (4) push_req(1'b0);
        push_req(1'b1);

        // Oversized value clamps to the largest board
        set_board(4'd15);
        push_req(1'b0);
        push_req(1'b0);

        // Rewriting the same size starts the search over
        set_board(4'd15);
        push_req(1'b0);

        // Long receiver hold-off while the sender keeps offering
        set_board(4'd5);
        idle_on = 1'b0;
        hold_requests++;
        repeat (40) push_req($urandom_range(0, 7) == 0);
        wait_drained();

        // Random phases
        while (n_pushed < TOTAL_ITEMS) begin
            if (n_pushed >= RAND_ITEMS) calm = 1'b1;
            idle_on = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 4 && big_walks < 3 && !calm) begin
                    size = $urandom_range(0, 1) ? 4'd8 : CFG_W'($urandom_range(9, 15));
                    big_walks++;
                end else if (pick < 12 && !calm) begin
                    size = 4'd7;
                end else begin
                    size = CFG_W'($urandom_range(0, 6));
                end
                set_board(size);
            end else begin
                wait_drained();
            end
            noisy = ($urandom_range(0, 4) == 0);
            if (noisy)
                count = $urandom_range(2, 20);
            else if (board_edge() == 8)
                count = 96;
            else if (board_edge() == 7)
                count = 45;
            else
                count = $urandom_range(2, 15);
            for (int i = 0; i < count && n_pushed < TOTAL_ITEMS; i++) begin
                if (noisy)
                    push_req($urandom_range(0, 1) == 1);
                else
                    push_req($urandom_range(0, 19) == 0);
            end
        end

        wait_drained();
        repeat (50) @(negedge aclk);
        if (solution_due.size() != 0) n_bad = n_bad + solution_due.size();
        if (n_bad == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
